// ===== sv/hwss_pkg.sv =====
// ----------------------------------------------------------------------------
// hwss_pkg
// Types and constants shared by the hunger-weighted slot scheduler.
// ----------------------------------------------------------------------------
package hwss_pkg;

  localparam int PRIO_W   = 8;
  localparam int PROD_W   = 2 * PRIO_W;
  localparam int FIELD_SW = 4;   // width of slot fields on the ports

  localparam logic [PRIO_W-1:0] HUNGER_ONE = PRIO_W'(1);
  localparam logic [PRIO_W-1:0] HUNGER_MAX = '1;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // One slot entry as held by a cell
  typedef struct packed {
    logic              ready;
    logic [PRIO_W-1:0] prio;
    logic [PRIO_W-1:0] count;
    logic [PRIO_W-1:0] hunger;
  } slot_t;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic shift;
    logic hunger_upd;
    logic refill;
    logic dec;
  } cell_ctl_t;

  typedef struct packed {
    logic                op;
    logic [FIELD_SW-1:0] slot;
    logic                ready_req;
    logic [PRIO_W-1:0]   priority_req;
    logic                msg_pending;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_SW-1:0] chosen_slot;
    logic                by_message;
    logic                counts_refilled;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE,
    S_FIN
  } state_e;

endpackage

// ===== sv/hwss_stream_if.sv =====
// ----------------------------------------------------------------------------
// hwss_stream_if
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface hwss_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/hwss_cell.sv =====
// ----------------------------------------------------------------------------
// hwss_cell
// One slot entry of the rotating ring: shift, load and in-place update.
// ----------------------------------------------------------------------------
module hwss_cell import hwss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctl_t         ctl_i,
  input  logic              win_i,
  input  logic              we_i,
  input  logic              wr_ready_i,
  input  logic [PRIO_W-1:0] wr_prio_i,
  input  slot_t             nbr_i,
  output slot_t             entry_o
);

  slot_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (we_i) begin
      entry_d.ready  = wr_ready_i;
      entry_d.prio   = wr_prio_i;
      entry_d.count  = wr_prio_i;
      entry_d.hunger = HUNGER_ONE;
    end else if (ctl_i.shift) begin
      entry_d = nbr_i;
    end else begin
      if (ctl_i.refill) begin
        entry_d.count = entry_q.prio;
      end
      if (ctl_i.dec && win_i && entry_q.count != '0) begin
        entry_d.count = entry_q.count - PRIO_W'(1);
      end
      if (ctl_i.hunger_upd) begin
        if (win_i) begin
          entry_d.hunger = HUNGER_ONE;
        end else if (entry_q.ready && entry_q.hunger != HUNGER_MAX) begin
          entry_d.hunger = entry_q.hunger + PRIO_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '{ready: 1'b0, prio: '0, count: '0, hunger: HUNGER_ONE};
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== sv/hwss_scan.sv =====
// ----------------------------------------------------------------------------
// hwss_scan
// Head comparator: weighs the entry at the ring head against the best so far.
// ----------------------------------------------------------------------------
module hwss_scan import hwss_pkg::*; #(
  parameter  int SLOTS  = 16,
  localparam int SLOT_W = $clog2(SLOTS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              sample_i,
  input  slot_t             head_i,
  input  logic [SLOT_W-1:0] head_idx_i,
  input  logic [SLOT_W-1:0] cur_i,
  output logic [SLOT_W-1:0] best_idx_o,
  output logic [PRIO_W-1:0] best_cnt_o
);

  // product stage
  logic              pv_q;
  logic [SLOT_W-1:0] pidx_q;
  logic [PROD_W-1:0] pprod_q;
  logic [PRIO_W-1:0] pcnt_q;
  logic              pelig_q;

  // best candidate
  logic              bv_q, bv_d;
  logic [SLOT_W-1:0] bidx_q;
  logic [PROD_W-1:0] bprod_q;
  logic [PRIO_W-1:0] bcnt_q;

  logic tie, take;

  // Equal keys: the current slot always holds; otherwise a slot after the
  // current one in ring order beats one that wraps round before it.
  always_comb begin
    tie  = (pidx_q == cur_i) ||
           (bidx_q != cur_i && pidx_q > cur_i && bidx_q < cur_i);
    take = pv_q && pelig_q &&
           (!bv_q || pprod_q > bprod_q ||
            (pprod_q == bprod_q && (pcnt_q > bcnt_q || (pcnt_q == bcnt_q && tie))));
    bv_d = clear_i ? 1'b0 : (take ? 1'b1 : bv_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      bv_q <= 1'b0;
    end else begin
      pv_q <= sample_i;
      bv_q <= bv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i) begin
      pidx_q  <= head_idx_i;
      pprod_q <= PROD_W'(head_i.count) * PROD_W'(head_i.hunger);
      pcnt_q  <= head_i.count;
      pelig_q <= head_i.ready || head_idx_i == cur_i;
    end
    if (take) begin
      bidx_q  <= pidx_q;
      bprod_q <= pprod_q;
      bcnt_q  <= pcnt_q;
    end
  end

  assign best_idx_o = bidx_q;
  assign best_cnt_o = bcnt_q;

endmodule

// ===== sv/hunger_weighted_slot_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// hunger_weighted_slot_scheduler_core
// Slot scheduler picking the ready slot with the largest count times hunger,
// or the server slot on a message.
// The slot table lives in a ring of SLOTS cells that rotates one place per
// cycle while scanning, past a single multiply-and-compare head; a selection
// pass rotates the ring, finishes the last compare and updates the table. A
// tick without a message takes one pass, or two when the winner's count was
// empty and the counts are refilled. A write item or a tick with a pending
// message goes straight from idle to the finish state. Each result waits in
// the finish state while the previous one still sits in the output register.
// One item is worked on at a time; a new one is taken while the previous
// result still waits in the output register.
module hunger_weighted_slot_scheduler_core import hwss_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [FIELD_SW-1:0] cfg_wdata_i,
  hwss_stream_if.sink         in_i,
  hwss_stream_if.source       out_o
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int IDX_W  = (SLOT_W > FIELD_SW) ? SLOT_W : FIELD_SW;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] scan_cnt_q;
  logic              pass2_q;
  logic              bymsg_q;
  logic [SLOT_W-1:0] cur_q;
  logic [SLOT_W-1:0] server_q, server_d;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              accept;
  logic              need_refill;
  logic              out_load;
  logic              scan_clear;
  logic              scan_sample;
  cell_ctl_t         cell_ctl;
  logic [SLOT_W-1:0] best_idx;
  logic [PRIO_W-1:0] best_cnt;
  logic [SLOT_W+FIELD_SW-1:0] cur_ext;

  slot_t entry [SLOTS];

  assign accept      = in_i.valid && in_i.ready;
  assign need_refill = (best_cnt == '0) && !pass2_q;
  assign cur_ext     = {{FIELD_SW{1'b0}}, cur_q};

  // ---- ring of slot cells ----
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    localparam int NB = (k + 1) % SLOTS;
    logic we, win;
    assign we  = accept && in_i.data.op == OP_WRITE &&
                 IDX_W'(in_i.data.slot) == IDX_W'(k);
    assign win = (best_idx == SLOT_W'(k));

    hwss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (cell_ctl),
      .win_i      (win),
      .we_i       (we),
      .wr_ready_i (in_i.data.ready_req),
      .wr_prio_i  (in_i.data.priority_req),
      .nbr_i      (entry[NB]),
      .entry_o    (entry[k])
    );
  end

  hwss_scan #(.SLOTS(SLOTS)) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (scan_clear),
    .sample_i   (scan_sample),
    .head_i     (entry[0]),
    .head_idx_i (scan_cnt_q),
    .cur_i      (cur_q),
    .best_idx_o (best_idx),
    .best_cnt_o (best_cnt)
  );

  // ---- server slot reduced into the ring: constant lookup per write value ----
  always_comb begin
    server_d = '0;
    for (int k = 0; k < (1 << FIELD_SW); k++) begin
      if (cfg_wdata_i == FIELD_SW'(k)) begin
        server_d = SLOT_W'(k % SLOTS);
      end
    end
  end

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.data.op == OP_WRITE || in_i.data.msg_pending) begin
            state_d = S_FIN;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_cnt_q == SLOT_W'(SLOTS - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN:  state_d = S_UPDATE;
      S_UPDATE: state_d = need_refill ? S_SCAN : S_FIN;
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // ---- outputs of the sequencer ----
  always_comb begin
    in_i.ready          = (state_q == S_IDLE);
    out_load            = (state_q == S_FIN) && (!out_valid_q || out_o.ready);
    scan_sample         = (state_q == S_SCAN);
    scan_clear          = (state_q != S_SCAN) && (state_q != S_DRAIN);
    cell_ctl.shift      = (state_q == S_SCAN);
    cell_ctl.hunger_upd = (state_q == S_UPDATE);
    cell_ctl.refill     = (state_q == S_UPDATE) && need_refill;
    cell_ctl.dec        = (state_q == S_UPDATE) && !need_refill;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_cnt_q  <= '0;
      pass2_q     <= 1'b0;
      bymsg_q     <= 1'b0;
      cur_q       <= '0;
      server_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        server_q <= server_d;
      end
      if (state_q == S_SCAN) begin
        scan_cnt_q <= (scan_cnt_q == SLOT_W'(SLOTS - 1)) ? '0 : scan_cnt_q + SLOT_W'(1);
      end
      if (state_q == S_IDLE) begin
        pass2_q <= 1'b0;
      end else if (state_q == S_UPDATE && need_refill) begin
        pass2_q <= 1'b1;
      end
      if (accept) begin
        bymsg_q <= (in_i.data.op == OP_TICK) && in_i.data.msg_pending;
        if (in_i.data.op == OP_TICK && in_i.data.msg_pending) begin
          cur_q <= server_q;
        end
      end
      if (state_q == S_UPDATE && !need_refill) begin
        cur_q <= best_idx;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.chosen_slot     <= cur_ext[FIELD_SW-1:0];
      out_q.by_message      <= bymsg_q;
      out_q.counts_refilled <= pass2_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // ---- checks ----
  // an accepted item always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("accepted item did not start");

  // ring must be back at its origin when the table is updated
  a_ring_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPDATE |-> scan_cnt_q == '0)
    else $error("ring not aligned at update");

  // a message grant never refills counts
  a_msg_no_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.by_message && out_q.counts_refilled))
    else $error("message grant flagged as refill");

  // a second pass only follows a refill
  a_pass2_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pass2_q) |-> $past(state_q) == S_UPDATE)
    else $error("second pass without refill");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hunger-weighted slot scheduler: a behavioural
// copy of the slot table predicts every grant, items are pushed through the
// valid/ready channels with random gaps and stalls, and each result is
// compared field by field against the oldest predicted grant.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import hwss_pkg::*;

  localparam int NSLOT     = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int END_WAIT  = 60;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [FIELD_SW-1:0] cfg_wdata_i;

  hwss_stream_if #(.item_t(in_item_t))  in_if ();
  hwss_stream_if #(.item_t(out_item_t)) out_if ();

  hunger_weighted_slot_scheduler_core #(.SLOTS(NSLOT)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Shadow slot table
  logic              sh_ready  [NSLOT];
  logic [PRIO_W-1:0] sh_prio   [NSLOT];
  logic [PRIO_W-1:0] sh_count  [NSLOT];
  logic [PRIO_W-1:0] sh_hunger [NSLOT];
  int                sh_current;
  int                sh_server;

  out_item_t granted_q[$];

  int  mismatches;
  int  orphan_results;
  int  idle_cycles;
  int  tick_cnt, write_cnt, msg_cnt, refill_cnt;
  bit  src_burst, snk_burst;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // One selection pass over the ring, with the hunger update
  function automatic int pick_slot();
    int best, i, k;
    logic [PROD_W-1:0] p_new, p_best;
    best = sh_current;
    i    = sh_current;
    do begin
      i = (i == NSLOT - 1) ? 0 : i + 1;
      if (sh_ready[i]) begin
        p_new  = sh_count[i] * sh_hunger[i];
        p_best = sh_count[best] * sh_hunger[best];
        if (p_new > p_best || (p_new == p_best && sh_count[i] > sh_count[best]))
          best = i;
      end
    end while (i != sh_current);
    for (k = 0; k < NSLOT; k++) begin
      if (k == best)
        sh_hunger[k] = HUNGER_ONE;
      else if (sh_ready[k] && sh_hunger[k] != HUNGER_MAX)
        sh_hunger[k] = sh_hunger[k] + 1'b1;
    end
    return best;
  endfunction

  function automatic out_item_t predict_grant(in_item_t it);
    out_item_t res;
    int win, k;
    res = '0;
    if (it.op == OP_WRITE) begin
      sh_ready[it.slot]  = it.ready_req;
      sh_prio[it.slot]   = it.priority_req;
      sh_count[it.slot]  = it.priority_req;
      sh_hunger[it.slot] = HUNGER_ONE;
      write_cnt++;
    end else if (it.msg_pending) begin
      sh_current = sh_server;
      res.by_message = 1'b1;
      tick_cnt++;
      msg_cnt++;
    end else begin
      win = pick_slot();
      if (sh_count[win] == '0) begin
        for (k = 0; k < NSLOT; k++)
          sh_count[k] = sh_prio[k];
        res.counts_refilled = 1'b1;
        refill_cnt++;
        win = pick_slot();
      end
      if (sh_count[win] != '0)
        sh_count[win] = sh_count[win] - 1'b1;
      sh_current = win;
      tick_cnt++;
    end
    res.chosen_slot = FIELD_SW'(sh_current);
    return res;
  endfunction

  function automatic in_item_t mk_write(int slot, bit rdy, int prio);
    in_item_t it;
    it              = '0;
    it.op           = OP_WRITE;
    it.slot         = FIELD_SW'(slot);
    it.ready_req    = rdy;
    it.priority_req = PRIO_W'(prio);
    it.msg_pending  = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic in_item_t mk_tick(bit msg);
    in_item_t it;
    // unused fields carry random noise
    it              = in_item_t'($urandom);
    it.op           = OP_TICK;
    it.msg_pending  = msg;
    return it;
  endfunction

  // Called and returns at a falling edge
  task automatic send_item(in_item_t it);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.data  = it;
    do @(posedge clk_i); while (!in_if.ready);
    granted_q.push_back(predict_grant(it));
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (granted_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_server(int val);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = FIELD_SW'(val);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    sh_server   = val % NSLOT;
  endtask

  function automatic in_item_t rand_item();
    int r;
    int prio;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      // small priorities keep counts running out, so refills happen often
      prio = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
      return mk_write($urandom_range(0, NSLOT - 1), $urandom_range(0, 4) != 0, prio);
    end
    return mk_tick(r < 35);
  endfunction

  // ---------------------------------------------------------------- checker
  initial begin : result_checker
    int        stall;
    out_item_t want;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = snk_burst ? 0 : $urandom_range(0, 18);
      out_if.ready = 1'b0;
      repeat (stall) @(negedge clk_i);
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      if (granted_q.size() == 0) begin
        orphan_results++;
        $display("unexpected result: slot %0d msg %0b refill %0b",
                 out_if.data.chosen_slot, out_if.data.by_message,
                 out_if.data.counts_refilled);
      end else begin
        want = granted_q.pop_front();
        if (out_if.data.chosen_slot !== want.chosen_slot ||
            out_if.data.by_message !== want.by_message ||
            out_if.data.counts_refilled !== want.counts_refilled) begin
          mismatches++;
          if (mismatches <= 10)
            $display("grant mismatch: expected slot %0d msg %0b refill %0b, got slot %0d msg %0b refill %0b",
                     want.chosen_slot, want.by_message, want.counts_refilled,
                     out_if.data.chosen_slot, out_if.data.by_message,
                     out_if.data.counts_refilled);
        end
      end
    end
  end

  // Watchdog: cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------ tests
  task automatic test_directed();
    send_item(mk_tick(1'b0));                  // empty table: refill, stays on 0
    send_item(mk_tick(1'b1));                  // message to server slot 0
    send_item(mk_write(15, 1'b1, 255));
    send_item(mk_write(0, 1'b1, 0));
    send_item(mk_write(7, 1'b0, 200));
    send_item(mk_tick(1'b0));                  // 15 wins on 255
    send_item(mk_write(3, 1'b1, 254));
    send_item(mk_write(9, 1'b1, 254));
    send_item(mk_tick(1'b0));                  // equal products, current slot 15 holds
    send_item(mk_tick(1'b0));
    send_item(mk_write(15, 1'b0, 0));          // drop slot 15
    send_item(mk_write(4, 1'b1, 2));
    send_item(mk_write(5, 1'b1, 4));
    send_item(mk_tick(1'b0));
    send_item(mk_tick(1'b0));
    write_server(15);
    send_item(mk_tick(1'b1));
    send_item(mk_tick(1'b0));
    // leave slot 3 as the only ready slot with a count, so the winner runs dry and forces a refill
    send_item(mk_write(3, 1'b1, 1));
    send_item(mk_write(9, 1'b0, 1));
    send_item(mk_write(4, 1'b0, 0));
    send_item(mk_write(5, 1'b0, 0));
    send_item(mk_tick(1'b0));
    send_item(mk_tick(1'b0));
    send_item(mk_tick(1'b0));
    write_server(0);
  endtask

  task automatic test_hunger_saturation();
    send_item(mk_write(2, 1'b1, 200));
    send_item(mk_write(5, 1'b1, 1));
    send_item(mk_write(9, 1'b1, 0));           // never wins, hunger climbs to the top
    src_burst = 1'b1;
    repeat (140) send_item(mk_tick(1'b0));
    src_burst = 1'b0;
    repeat (140) send_item(mk_tick(1'b0));
  endtask

  task automatic test_random_mix();
    int ph;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       write_server(0);
        1:       write_server(15);
        default: write_server($urandom_range(0, NSLOT - 1));
      endcase
      src_burst = (ph == 2) || (ph == 5);
      snk_burst = (ph == 3) || (ph == 5);
      repeat (135) send_item(rand_item());
    end
    src_burst = 1'b0;
    snk_burst = 1'b0;
  endtask

  task automatic test_drained_restart();
    repeat (3) begin
      repeat (6) send_item(rand_item());
      wait_drained();
      src_burst = 1'b1;
      repeat (4) send_item(mk_tick(1'b0));
      src_burst = 1'b0;
    end
  endtask

  initial begin
    int k;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    mismatches     = 0;
    orphan_results = 0;
    idle_cycles    = 0;
    tick_cnt = 0; write_cnt = 0; msg_cnt = 0; refill_cnt = 0;
    src_burst = 1'b0;
    snk_burst = 1'b0;
    for (k = 0; k < NSLOT; k++) begin
      sh_ready[k]  = 1'b0;
      sh_prio[k]   = '0;
      sh_count[k]  = '0;
      sh_hunger[k] = HUNGER_ONE;
    end
    sh_current = 0;
    sh_server  = 0;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_hunger_saturation();
    test_random_mix();
    test_drained_restart();

    wait_drained();
    repeat (END_WAIT) @(negedge clk_i);

    $display("Run covered %0d ticks (%0d granted by message, %0d with refill)",
             tick_cnt, msg_cnt, refill_cnt);
    $display("and %0d slot writes, with server slot settings 0, 15 and random", write_cnt);
    if (mismatches == 0 && orphan_results == 0 && granted_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d unexpected, %0d missing",
               mismatches, orphan_results, granted_q.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/hwss_pkg.sv
sv/hwss_stream_if.sv
sv/hwss_cell.sv
sv/hwss_scan.sv
sv/hunger_weighted_slot_scheduler_core.sv
sim/tb.sv
